### sv/csc_pkg.sv
`default_nettype none

package csc_pkg;

  localparam int unsigned CORDIC_STAGES = 24;
  localparam int unsigned NSTG = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
  localparam int unsigned SW = 5;
  localparam int unsigned LW = 44;
  localparam int unsigned GUARD = 8;
  localparam int unsigned RW = LW - GUARD;
  localparam int unsigned IN_W = 96;
  localparam int unsigned OUT_W = 232;

  localparam logic [1:0] OP_CART = 2'd0;
  localparam logic [1:0] OP_SPH  = 2'd1;
  localparam logic [1:0] OP_CYL  = 2'd2;

  localparam logic signed [LW-1:0] INV_GAIN_Q30 = 44'sd652032874;
  localparam logic [31:0] INV_GAIN_Q32 = 32'h9B74_EDA8;
  localparam logic [31:0] HALF_TURN = 32'h8000_0000;
  localparam logic [31:0] THREE_QUARTER_TURN = 32'hC000_0000;
  localparam logic [31:0] EIGHTH_TURN = 32'h2000_0000;

  localparam logic [31:0] ATAN_TURNS [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic                 vec;
    logic                 hold;
    logic [1:0]           q;
    logic signed [LW-1:0] x;
    logic signed [LW-1:0] y;
    logic [31:0]          z;
  } lane_t;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] c;
  } point_t;

  typedef struct packed {
    logic signed [31:0] co;
    logic signed [31:0] si;
  } cs_t;

  typedef struct packed {
    logic [1:0]           op;
    logic signed [RW-1:0] px;
    logic signed [RW-1:0] py;
    logic signed [RW-1:0] pz;
    logic signed [RW-1:0] rs;
    logic signed [RW-1:0] rc;
    logic [30:0]          polar;
    logic [31:0]          azim;
  } res_t;

  function automatic logic signed [LW-1:0] guard(logic signed [31:0] v);
    return {{(LW-40){v[31]}}, v, 8'h00};
  endfunction

  function automatic lane_t init_rot(logic [31:0] ang);
    lane_t       l;
    logic [31:0] t;
    t      = ang + EIGHTH_TURN;
    l.vec  = 1'b0;
    l.hold = 1'b0;
    l.q    = t[31:30];
    l.x    = INV_GAIN_Q30;
    l.y    = '0;
    l.z    = ang - {t[31:30], 30'd0};
    return l;
  endfunction

  function automatic lane_t init_vec(logic signed [LW-1:0] x, logic signed [LW-1:0] y);
    lane_t l;
    l.vec  = 1'b1;
    l.hold = 1'b0;
    l.q    = 2'd0;
    l.x    = x;
    l.y    = y;
    l.z    = '0;
    if (y == '0) begin
      l.hold = 1'b1;
      if (x[LW-1]) begin
        l.x = -x;
        l.z = HALF_TURN;
      end
    end else if (x[LW-1]) begin
      l.x = -x;
      l.y = -y;
      l.z = HALF_TURN;
    end
    return l;
  endfunction

  function automatic cs_t quad_map(lane_t l);
    cs_t r;
    unique case (l.q)
      2'd0: begin
        r.co = l.x[31:0];
        r.si = l.y[31:0];
      end
      2'd1: begin
        r.co = 32'(-l.y);
        r.si = l.x[31:0];
      end
      2'd2: begin
        r.co = 32'(-l.x);
        r.si = 32'(-l.y);
      end
      default: begin
        r.co = l.y[31:0];
        r.si = 32'(-l.x);
      end
    endcase
    return r;
  endfunction

  function automatic logic signed [RW-1:0] unguard(logic signed [LW-1:0] v);
    logic signed [LW-1:0] t;
    t = v + LW'(128);
    return t[LW-1:GUARD];
  endfunction

  function automatic logic [31:0] sat32(logic signed [RW-1:0] v);
    if (v > $signed(36'sh07FFFFFFF)) begin
      return 32'h7FFF_FFFF;
    end else if (v < $signed(36'shF80000000)) begin
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic logic [32:0] sat33(logic signed [RW-1:0] v);
    if (v > $signed(36'sh0FFFFFFFF)) begin
      return 33'h0_FFFF_FFFF;
    end else if (v < $signed(36'shF00000000)) begin
      return 33'h1_0000_0000;
    end
    return v[32:0];
  endfunction

endpackage

`default_nettype wire

### sv/csc_cell.sv
`default_nettype none

module csc_cell import csc_pkg::*; (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [SW-1:0] stage_i,
  input  lane_t         lane_i,
  output lane_t         lane_o
);

  lane_t                lane_d, lane_q;
  logic signed [LW-1:0] dx, dy;
  logic [31:0]          at;
  logic                 d_pos;

  always_comb begin
    dx     = $signed(lane_i.y) >>> stage_i;
    dy     = $signed(lane_i.x) >>> stage_i;
    at     = ATAN_TURNS[stage_i];
    d_pos  = lane_i.vec ? lane_i.y[LW-1] : ~lane_i.z[31];
    lane_d = lane_i;
    if (!lane_i.hold) begin
      if (d_pos) begin
        lane_d.x = lane_i.x - dx;
        lane_d.y = lane_i.y + dy;
        lane_d.z = lane_i.z - at;
      end else begin
        lane_d.x = lane_i.x + dx;
        lane_d.y = lane_i.y - dy;
        lane_d.z = lane_i.z + at;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign lane_o = lane_q;

endmodule

`default_nettype wire

### sv/csc_gain.sv
`default_nettype none

module csc_gain import csc_pkg::*; (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [LW-1:0] x_i,
  output logic [LW-1:0] mag_o
);

  localparam int unsigned HW = LW - 24 + 32;
  localparam int unsigned LOW = 24 + 32;

  logic [HW-1:0]  hi_d, hi_q;
  logic [LOW-1:0] lo_d, lo_q;
  logic [LOW:0]   low_sum;
  logic [LW-1:0]  mag_d, mag_q;

  always_comb begin
    hi_d    = x_i[LW-1:24] * INV_GAIN_Q32;
    lo_d    = x_i[23:0] * INV_GAIN_Q32;
    low_sum = (LOW+1)'({hi_q[7:0], 24'd0}) + (LOW+1)'(lo_q) + (LOW+1)'(33'h0_8000_0000);
    mag_d   = LW'(hi_q[HW-1:8]) + LW'(low_sum[LOW:32]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hi_q  <= hi_d;
      lo_q  <= lo_d;
      mag_q <= mag_d;
    end
  end

  assign mag_o = mag_q;

endmodule

`default_nettype wire

### sv/coordinate_system_conversion_top.sv
// Converts one 3D point per transfer between Cartesian, spherical and cylindrical form.
// Input: s_axis_tuser selects the system of the point and s_axis_tdata carries its three
// coordinates. Output: one transfer per input transfer, in order, with the point in all
// three systems and m_axis_tuser set when the input system was known; otherwise all
// result fields are zero.
// The datapath is three rows of CORDIC cells, one micro-rotation per cell and per cycle
// while not frozen: rows a and b for sine, cosine and the first magnitude, row c for the
// polar angle of Cartesian points. Gain correction follows each row; the products sit
// between rows a, b and row c. Throughput is one transfer per cycle while the output
// does not stall, set by the one-cell-per-stage rows and the registered multipliers.
// When the receiver stalls, the output register holds its result and the pipeline
// keeps moving while it has empty slots; it freezes, and s_axis_tready falls, only
// when a result reaches the end and the output register is still full.
// Reset clears all valid flags; no result is presented after reset until new input.
`default_nettype none

module coordinate_system_conversion_top import csc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // coord_a [31:0], coord_b [63:32], coord_c [95:64]
  input  logic [IN_W-1:0]  s_axis_tdata,
  // operation [1:0]
  input  logic [1:0]       s_axis_tuser,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // pos_x [31:0], pos_y [63:32], pos_z [95:64], sphere_radius [128:96],
  // polar_angle [159:129], azimuth [191:160], cyl_radius [224:192], zeros above
  output logic [OUT_W-1:0] m_axis_tdata,
  // valid_res [0]
  output logic [0:0]       m_axis_tuser
);

  logic en, out_load;

  lane_t  la [NSTG+1];
  lane_t  lb [NSTG+1];
  lane_t  lc [NSTG+1];
  lane_t  la0_q, lb0_q, la0_d, lb0_d, lc0_q, lc0_d;
  point_t in_pt;
  point_t p1_q [NSTG+1];
  res_t   r2_q [NSTG+1];
  logic [NSTG:0] v1_q, v2_q;

  point_t m1_pt_q, m2_pt_q;
  lane_t  m1_la_q, m1_lb_q, m2_la_q, m2_lb_q, m4_lc_q, m5_lc_q;
  cs_t    m1_csa_q, m1_csb_q, m2_csb_q;
  logic signed [33:0] m2_s_q, m2_c_q;
  logic signed [63:0] prod_s, prod_c;
  logic signed [65:0] pp_x, pp_y;
  logic [LW-1:0] ga, gb, gc;
  logic signed [LW-1:0] mg_a, mg_b, mg_c;
  res_t   res_d, m4_res_q, m5_res_q;
  logic   m1_v_q, m2_v_q, m4_v_q, m5_v_q, out_v_q;

  logic [31:0]      th;
  logic [30:0]      polar_o;
  logic signed [RW-1:0] rs_o;
  logic [OUT_W-1:0] out_data_q;
  logic             out_user_q;

  assign out_load      = ~out_v_q | m_axis_tready;
  assign en            = out_load | ~m5_v_q;
  assign s_axis_tready = en;

  always_comb begin
    in_pt.op = s_axis_tuser;
    in_pt.a  = s_axis_tdata[31:0];
    in_pt.b  = s_axis_tdata[63:32];
    in_pt.c  = s_axis_tdata[95:64];
    unique case (in_pt.op)
      OP_CART: begin
        la0_d = init_vec(guard(in_pt.a), guard(in_pt.b));
        lb0_d = init_rot(in_pt.c);
      end
      OP_CYL: begin
        la0_d = init_rot(in_pt.b);
        lb0_d = init_vec(guard(in_pt.c), guard(in_pt.a));
      end
      default: begin
        la0_d = init_rot(in_pt.b);
        lb0_d = init_rot(in_pt.c);
      end
    endcase
  end

  assign la[0] = la0_q;
  assign lb[0] = lb0_q;
  assign lc[0] = lc0_q;

  for (genvar k = 0; k < NSTG; k++) begin : g_row
    csc_cell u_cell_a (
      .clk_i  (clk_i),
      .en_i   (en),
      .stage_i(SW'(k)),
      .lane_i (la[k]),
      .lane_o (la[k+1])
    );
    csc_cell u_cell_b (
      .clk_i  (clk_i),
      .en_i   (en),
      .stage_i(SW'(k)),
      .lane_i (lb[k]),
      .lane_o (lb[k+1])
    );
    csc_cell u_cell_c (
      .clk_i  (clk_i),
      .en_i   (en),
      .stage_i(SW'(k)),
      .lane_i (lc[k]),
      .lane_o (lc[k+1])
    );
  end

  csc_gain u_gain_a (
    .clk_i(clk_i),
    .en_i (en),
    .x_i  (la[NSTG].x),
    .mag_o(ga)
  );

  csc_gain u_gain_b (
    .clk_i(clk_i),
    .en_i (en),
    .x_i  (lb[NSTG].x),
    .mag_o(gb)
  );

  csc_gain u_gain_c (
    .clk_i(clk_i),
    .en_i (en),
    .x_i  (lc[NSTG].x),
    .mag_o(gc)
  );

  always_comb begin
    prod_s = m1_pt_q.a * m1_csa_q.si;
    prod_c = m1_pt_q.a * m1_csa_q.co;
    pp_x   = m2_s_q * m2_csb_q.co + 66'sh0_2000_0000;
    pp_y   = m2_s_q * m2_csb_q.si + 66'sh0_2000_0000;
    mg_a   = m2_la_q.hold ? m2_la_q.x : $signed(ga);
    mg_b   = m2_lb_q.hold ? m2_lb_q.x : $signed(gb);
    lc0_d  = init_vec(guard(m2_pt_q.c), mg_a);
    res_d  = '0;
    res_d.op = m2_pt_q.op;
    unique case (m2_pt_q.op)
      OP_CART: begin
        res_d.px   = RW'(m2_pt_q.a);
        res_d.py   = RW'(m2_pt_q.b);
        res_d.pz   = RW'(m2_pt_q.c);
        res_d.rc   = unguard(mg_a);
        res_d.azim = m2_la_q.z;
      end
      OP_SPH: begin
        res_d.px    = pp_x[65:30];
        res_d.py    = pp_y[65:30];
        res_d.pz    = RW'(m2_c_q);
        res_d.rc    = RW'(m2_s_q);
        res_d.rs    = RW'(m2_pt_q.a);
        res_d.polar = m2_pt_q.b[30:0];
        res_d.azim  = m2_pt_q.c;
      end
      OP_CYL: begin
        res_d.px    = RW'(m2_c_q);
        res_d.py    = RW'(m2_s_q);
        res_d.pz    = RW'(m2_pt_q.c);
        res_d.rc    = RW'(m2_pt_q.a);
        res_d.rs    = unguard(mg_b);
        res_d.polar = m2_lb_q.z[30:0];
        res_d.azim  = m2_pt_q.b;
      end
      default: begin
        res_d    = '0;
        res_d.op = m2_pt_q.op;
      end
    endcase
  end

  always_comb begin
    mg_c = m5_lc_q.hold ? m5_lc_q.x : $signed(gc);
    th   = m5_lc_q.z;
    if (th > THREE_QUARTER_TURN) begin
      th = '0;
    end else if (th > HALF_TURN) begin
      th = HALF_TURN;
    end
    rs_o    = m5_res_q.rs;
    polar_o = m5_res_q.polar;
    if (m5_res_q.op == OP_CART) begin
      rs_o    = unguard(mg_c);
      polar_o = th[30:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= '0;
      v2_q    <= '0;
      m1_v_q  <= 1'b0;
      m2_v_q  <= 1'b0;
      m4_v_q  <= 1'b0;
      m5_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (en) begin
        v1_q   <= {v1_q[NSTG-1:0], s_axis_tvalid};
        m1_v_q <= v1_q[NSTG];
        m2_v_q <= m1_v_q;
        v2_q   <= {v2_q[NSTG-1:0], m2_v_q};
        m4_v_q <= v2_q[NSTG];
        m5_v_q <= m4_v_q;
      end
      if (out_load) begin
        out_v_q <= m5_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      la0_q    <= la0_d;
      lb0_q    <= lb0_d;
      p1_q[0]  <= in_pt;
      for (int i = 0; i < NSTG; i++) begin
        p1_q[i+1] <= p1_q[i];
        r2_q[i+1] <= r2_q[i];
      end
      m1_pt_q  <= p1_q[NSTG];
      m1_la_q  <= la[NSTG];
      m1_lb_q  <= lb[NSTG];
      m1_csa_q <= quad_map(la[NSTG]);
      m1_csb_q <= quad_map(lb[NSTG]);
      m2_pt_q  <= m1_pt_q;
      m2_la_q  <= m1_la_q;
      m2_lb_q  <= m1_lb_q;
      m2_csb_q <= m1_csb_q;
      m2_s_q   <= 34'((prod_s + 64'sh2000_0000) >>> 30);
      m2_c_q   <= 34'((prod_c + 64'sh2000_0000) >>> 30);
      lc0_q    <= lc0_d;
      r2_q[0]  <= res_d;
      m4_res_q <= r2_q[NSTG];
      m4_lc_q  <= lc[NSTG];
      m5_res_q <= m4_res_q;
      m5_lc_q  <= m4_lc_q;
    end
    if (out_load) begin
      out_data_q <= {7'd0, sat33(m5_res_q.rc), m5_res_q.azim, polar_o, sat33(rs_o),
                     sat32(m5_res_q.pz), sat32(m5_res_q.py), sat32(m5_res_q.px)};
      out_user_q <= (m5_res_q.op == OP_CART) || (m5_res_q.op == OP_SPH) ||
                    (m5_res_q.op == OP_CYL);
    end
  end

  assign m_axis_tvalid   = out_v_q;
  assign m_axis_tdata    = out_data_q;
  assign m_axis_tuser[0] = out_user_q;

`ifndef ASSERT_OFF
  a_unknown_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("unknown system must give an all-zero result");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready && m5_v_q)
    else $error("input stalled without a waiting result");

  a_rise_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(m5_v_q))
    else $error("result appeared without a pipeline entry");

  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready && m5_v_q |=> $stable(m5_res_q) && m5_v_q)
    else $error("last pipeline stage changed while frozen");
`endif

endmodule

`default_nettype wire
